FILE: hw/rtl/ovc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovc_pkg
// Shared types, codes and constants of the object view cull unit.
// ----------------------------------------------------------------------------
package ovc_pkg;

    // Objects kept per sector before acceptance stops.
    localparam logic [7:0] MAX_OBJECTS = 8'd128;

    // 1.0 in Q16.16, sized for the widened bound arithmetic.
    localparam logic signed [33:0] ONE_Q16 = 34'sd65536;

    // Projected offsets saturate to plus or minus this many columns.
    localparam logic [12:0] COL_SAT = 13'd4096;

    // Configuration reset values.
    localparam logic [30:0] FOCAL_RESET  = 31'd65536;
    localparam logic [11:0] CENTER_RESET = 12'd160;
    localparam logic [11:0] LEFT_RESET   = 12'd0;
    localparam logic [11:0] RIGHT_RESET  = 12'd319;

    // Top quotient bit of the divider, which develops one bit per cycle down
    // to bit zero.
    localparam logic [3:0] DIV_TOP_BIT = 4'd13;

    typedef enum logic [1:0] {
        KIND_SPRITE = 2'd0,
        KIND_FRAME  = 2'd1,
        KIND_MODEL  = 2'd2,
        KIND_OTHER  = 2'd3
    } object_kind_t;

    typedef enum logic [1:0] {
        REG_FOCAL_LENGTH = 2'd0,
        REG_CENTER_X     = 2'd1,
        REG_WINDOW_LEFT  = 2'd2,
        REG_WINDOW_RIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUNDS,
        S_PLANES,
        S_WAIT_LO,
        S_WAIT_HI,
        S_DONE
    } cull_state_t;

    typedef enum logic [2:0] {
        P_IDLE,
        P_MUL,
        P_PREP,
        P_DIV,
        P_DONE
    } proj_state_t;

    // Request to the projection unit: a horizontal bound in Q16.16.
    typedef struct packed {
        logic               start;
        logic signed [33:0] bound;
    } proj_req_t;

    // Response: rounded, saturated column offset, valid while done is high.
    typedef struct packed {
        logic               done;
        logic signed [13:0] col;
    } proj_rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ovc_proj.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovc_proj
// Iterative projection unit: round(bound * focal / (depth * 2^16)), saturated.
// ----------------------------------------------------------------------------
module ovc_proj (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ovc_pkg::proj_req_t req,
    input  wire logic [30:0]       focal_length,
    input  wire logic [30:0]       depth,
    output ovc_pkg::proj_rsp_t     rsp
);

    ovc_pkg::proj_state_t state_reg, state_next;

    logic [31:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [30:0] depth_reg, depth_next;
    logic [62:0] prod_reg, prod_next;
    logic [64:0] rem_reg, rem_next;
    logic [60:0] dsh_reg, dsh_next;
    logic [13:0] quo_reg, quo_next;
    logic [3:0]  step_reg, step_next;

    logic [33:0] bound_abs;
    logic [65:0] diff;
    logic        over;
    logic [12:0] col_mag;

    assign bound_abs = req.bound[33] ? 34'(-req.bound) : req.bound;
    assign diff      = {1'b0, rem_reg} - {5'b0, dsh_reg};
    assign over      = quo_reg[13] || (quo_reg[12:0] > ovc_pkg::COL_SAT);
    assign col_mag   = over ? ovc_pkg::COL_SAT : quo_reg[12:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ovc_pkg::P_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        depth_reg <= depth_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        quo_reg   <= quo_next;
        step_reg  <= step_next;
    end

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        depth_next = depth_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        rsp.done   = 1'b0;
        rsp.col    = neg_reg ? 14'(-{1'b0, col_mag}) : {1'b0, col_mag};

        unique case (state_reg) inside
            ovc_pkg::P_IDLE, ovc_pkg::P_DONE: begin
                rsp.done = (state_reg == ovc_pkg::P_DONE);
                if (req.start) begin
                    mag_next   = bound_abs[31:0];
                    neg_next   = req.bound[33];
                    depth_next = depth;
                    state_next = ovc_pkg::P_MUL;
                end else begin
                    state_next = ovc_pkg::P_IDLE;
                end
            end
            ovc_pkg::P_MUL: begin
                prod_next  = 63'(mag_reg) * 63'(focal_length);
                state_next = ovc_pkg::P_PREP;
            end
            ovc_pkg::P_PREP: begin
                // Twice the numerator plus the divisor, less one for negative
                // bounds, turns the rounding into a plain floor division by
                // twice the divisor.
                rem_next   = {prod_reg, 1'b0} + {18'b0, depth_reg, 16'b0}
                             - {64'b0, neg_reg};
                dsh_next   = {depth_reg, 30'b0};
                quo_next   = '0;
                step_next  = ovc_pkg::DIV_TOP_BIT;
                state_next = ovc_pkg::P_DIV;
            end
            ovc_pkg::P_DIV: begin
                quo_next = {quo_reg[12:0], ~diff[65]};
                if (!diff[65]) begin
                    rem_next = diff[64:0];
                end
                dsh_next  = {1'b0, dsh_reg[60:1]};
                step_next = step_reg - 4'd1;
                if (step_reg == 4'd0) begin
                    state_next = ovc_pkg::P_DONE;
                end
            end
            default: begin
                state_next = ovc_pkg::P_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/object_view_cull_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// object_view_cull_unit
// Bounding-sphere view cull of objects with a per-sector draw slot counter.
// ----------------------------------------------------------------------------
// One request carries one object in view space. The unit takes one request at
// a time: s_tready is high only while the sequencer is idle. A sprite, a
// frame, a rejected or a trivially decided object passes through the bounds
// and plane states to its result. A 3D model that needs the column window
// test goes through the shared projection unit once or twice; each pass
// takes a multiply, a setup step, fourteen restoring divide steps and a
// result step.
// The finished result sits in an output register, so the next request is
// taken while it waits for m_tready. Configuration writes are always ready
// and must only be issued while the unit is idle. Accepted objects receive
// consecutive draw slots starting at zero; sector_start clears the count
// before its own object, and once the count reaches its maximum every other
// object of the sector is rejected with slot zero.
// ----------------------------------------------------------------------------
module object_view_cull_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] view_x, [63:32] view_z, [94:64] radius, [95] zero
    input  wire logic [95:0] s_tdata,
    // [0] sector_start, [1] needs_transform, [3:2] object_kind
    input  wire logic [3:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] slot
    output logic [7:0]       m_tdata,
    // [0] accepted
    output logic [0:0]       m_tuser
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are taken in any cycle.
    // ------------------------------------------------------------------
    logic [30:0] focal_reg;
    logic [11:0] center_reg;
    logic [11:0] left_reg;
    logic [11:0] right_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg  <= ovc_pkg::FOCAL_RESET;
            center_reg <= ovc_pkg::CENTER_RESET;
            left_reg   <= ovc_pkg::LEFT_RESET;
            right_reg  <= ovc_pkg::RIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ovc_pkg::REG_FOCAL_LENGTH: focal_reg  <= cfg_data[30:0];
                ovc_pkg::REG_CENTER_X:     center_reg <= cfg_data[11:0];
                ovc_pkg::REG_WINDOW_LEFT:  left_reg   <= cfg_data[11:0];
                ovc_pkg::REG_WINDOW_RIGHT: right_reg  <= cfg_data[11:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and object registers.
    // ------------------------------------------------------------------
    ovc_pkg::cull_state_t state_reg, state_next;

    logic [7:0]         count_reg, count_next;
    logic               flag_reg, flag_next;
    logic [1:0]         kind_reg, kind_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] z_reg, z_next;
    logic [30:0]        r_reg, r_next;

    logic signed [33:0] zmax_reg, zmax_next;
    logic signed [33:0] zmin_reg, zmin_next;
    logic signed [33:0] xmax_reg, xmax_next;
    logic signed [33:0] xmin_reg, xmin_next;
    logic               keep_reg, keep_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_acc_reg, m_acc_next;
    logic [7:0]         m_slot_reg, m_slot_next;

    ovc_pkg::proj_req_t proj_req;
    ovc_pkg::proj_rsp_t proj_rsp;

    // Widened operands for the bound and plane tests.
    logic signed [33:0] x_wide, z_wide, r_wide;
    logic signed [34:0] left_plane_sum;
    logic signed [14:0] column;

    assign x_wide = {{2{x_reg[31]}}, x_reg};
    assign z_wide = {{2{z_reg[31]}}, z_reg};
    assign r_wide = {3'b0, r_reg};

    // xmax < -zmax is the same test as xmax + zmax < 0, which cannot overflow.
    assign left_plane_sum = {xmax_reg[33], xmax_reg} + {zmax_reg[33], zmax_reg};

    // Column of the projection unit's current result.
    assign column = {proj_rsp.col[13], proj_rsp.col} + $signed({3'b0, center_reg});

    assign s_tready = (state_reg == ovc_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_slot_reg;
    assign m_tuser  = m_acc_reg;

    ovc_proj u_proj (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (proj_req),
        .focal_length (focal_reg),
        .depth        (z_reg[30:0]),
        .rsp          (proj_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ovc_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        flag_reg   <= flag_next;
        kind_reg   <= kind_next;
        x_reg      <= x_next;
        z_reg      <= z_next;
        r_reg      <= r_next;
        zmax_reg   <= zmax_next;
        zmin_reg   <= zmin_next;
        xmax_reg   <= xmax_next;
        xmin_reg   <= xmin_next;
        keep_reg   <= keep_next;
        m_acc_reg  <= m_acc_next;
        m_slot_reg <= m_slot_next;
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        kind_next      = kind_reg;
        x_next         = x_reg;
        z_next         = z_reg;
        r_next         = r_reg;
        zmax_next      = zmax_reg;
        zmin_next      = zmin_reg;
        xmax_next      = xmax_reg;
        xmin_next      = xmin_reg;
        keep_next      = keep_reg;
        m_acc_next     = m_acc_reg;
        m_slot_next    = m_slot_reg;
        proj_req.start = 1'b0;
        proj_req.bound = xmin_reg;

        // A waiting result leaves once the sink takes it.
        m_valid_next = m_valid_reg && !m_tready;

        unique case (state_reg)
            ovc_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    flag_next = s_tuser[1];
                    kind_next = s_tuser[3:2];
                    x_next    = s_tdata[31:0];
                    z_next    = s_tdata[63:32];
                    r_next    = s_tdata[94:64];
                    // A new sector clears the count before its first object.
                    if (s_tuser[0]) begin
                        count_next = '0;
                    end
                    state_next = ovc_pkg::S_BOUNDS;
                end
            end

            ovc_pkg::S_BOUNDS: begin
                zmax_next  = z_wide + r_wide;
                zmin_next  = z_wide - r_wide;
                xmax_next  = x_wide + r_wide;
                xmin_next  = x_wide - r_wide;
                state_next = ovc_pkg::S_PLANES;
            end

            ovc_pkg::S_PLANES: begin
                keep_next  = 1'b0;
                state_next = ovc_pkg::S_DONE;
                if ((count_reg < ovc_pkg::MAX_OBJECTS) && flag_reg) begin
                    case (kind_reg) inside
                        ovc_pkg::KIND_SPRITE, ovc_pkg::KIND_FRAME: begin
                            keep_next = (z_wide >= ovc_pkg::ONE_Q16);
                        end
                        ovc_pkg::KIND_MODEL: begin
                            if ((zmax_reg < ovc_pkg::ONE_Q16) ||
                                (left_plane_sum < 35'sd0) ||
                                (xmin_reg > zmax_reg)) begin
                                // Behind the near plane or outside a side plane.
                                keep_next = 1'b0;
                            end else if (zmin_reg <= 34'sd0) begin
                                // Reaching to or behind depth zero is kept outright.
                                keep_next = 1'b1;
                            end else begin
                                proj_req.start = 1'b1;
                                proj_req.bound = xmin_reg;
                                state_next     = ovc_pkg::S_WAIT_LO;
                            end
                        end
                        default: begin
                            keep_next = 1'b0;
                        end
                    endcase
                end
            end

            ovc_pkg::S_WAIT_LO: begin
                if (proj_rsp.done) begin
                    if (column > $signed({3'b0, right_reg})) begin
                        // Left edge already past the window's right side.
                        keep_next  = 1'b0;
                        state_next = ovc_pkg::S_DONE;
                    end else begin
                        proj_req.start = 1'b1;
                        proj_req.bound = xmax_reg;
                        state_next     = ovc_pkg::S_WAIT_HI;
                    end
                end
            end

            ovc_pkg::S_WAIT_HI: begin
                if (proj_rsp.done) begin
                    keep_next  = (column >= $signed({3'b0, left_reg}));
                    state_next = ovc_pkg::S_DONE;
                end
            end

            ovc_pkg::S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_acc_next   = keep_reg;
                    m_slot_next  = keep_reg ? count_reg : 8'd0;
                    if (keep_reg) begin
                        count_next = count_reg + 8'd1;
                    end
                    state_next = ovc_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = ovc_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // The per-sector count never runs past its limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ovc_pkg::MAX_OBJECTS)
    else $error("accepted count exceeds its maximum");

    // A rejected object always carries slot zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
    else $error("rejected object with nonzero slot");

    // An accepted object's slot lies below the sector limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata < ovc_pkg::MAX_OBJECTS))
    else $error("slot out of range");

    // The projection unit reports only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        proj_rsp.done |-> ((state_reg == ovc_pkg::S_WAIT_LO) ||
                           (state_reg == ovc_pkg::S_WAIT_HI)))
    else $error("projection result outside a wait state");
`endif

endmodule
`default_nettype wire
